/* sv/fcsd_pkg.sv */
// Shared types and constants for the flash command sequence decoder.
package fcsd_pkg;

  // Record depth and the slots that are actually stored
  localparam int unsigned SEQUENCE_DEPTH = 10;
  localparam int unsigned COUNT_W        = 4;
  localparam int unsigned REC_SLOTS      = 6;
  localparam int unsigned SLOT_W         = 3;
  localparam int unsigned REC_ADDR_W     = 12;

  // Command addresses and data codes
  localparam logic [REC_ADDR_W-1:0] ADDR_A = 12'h555;
  localparam logic [REC_ADDR_W-1:0] ADDR_B = 12'h2AA;
  localparam logic [7:0] LOW_A       = 8'h55;
  localparam logic [7:0] LOW_B       = 8'hAA;
  localparam logic [7:0] DATA_UNLOCK1 = 8'hAA;
  localparam logic [7:0] DATA_UNLOCK2 = 8'h55;
  localparam logic [7:0] DATA_ERASE   = 8'h80;
  localparam logic [7:0] DATA_SECTOR  = 8'h30;
  localparam logic [7:0] DATA_CHIP    = 8'h10;
  localparam logic [7:0] DATA_PROGRAM = 8'hA0;
  localparam logic [7:0] DATA_ID      = 8'h90;
  localparam logic [7:0] DATA_RESET   = 8'hF0;

  // Decoded operation codes
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_PROGRAM = 3'd1,
    OP_SECTOR  = 3'd2,
    OP_CHIP    = 3'd3,
    OP_ID      = 3'd4,
    OP_RESET   = 3'd5
  } op_t;

  // One bus write
  typedef struct packed {
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } req_item_t;

  // One decode result
  typedef struct packed {
    op_t         operation;
    logic [15:0] target_address;
    logic [7:0]  program_data;
    logic        id_mode_active;
  } res_item_t;

endpackage

/* sv/fcsd_in_reg.sv */
// Input register stage that captures one bus write request.
module fcsd_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  input  fcsd_pkg::req_item_t request,
  output logic                request_stall,
  input  logic                advance,
  output logic                item_valid,
  output fcsd_pkg::req_item_t item
);

  // Hold while a captured request cannot move on
  assign request_stall = item_valid && !advance;

  // Capture a new request whenever the stage is free
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!request_stall) begin
      item_valid <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!request_stall && request_valid) begin
      item <= request;
    end
  end

endmodule

/* sv/fcsd_decode.sv */
// Sequence record, command matching and result register.
module fcsd_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  fcsd_pkg::req_item_t item,
  output logic                advance,
  output logic                result_valid,
  input  logic                result_stall,
  output fcsd_pkg::res_item_t result
);

  logic [fcsd_pkg::COUNT_W-1:0]    count;
  logic [fcsd_pkg::COUNT_W-1:0]    count_next;
  logic                            id_flag;
  logic                            id_flag_next;
  logic [fcsd_pkg::REC_ADDR_W-1:0] rec_addr [fcsd_pkg::REC_SLOTS];
  logic [7:0]                      rec_data [fcsd_pkg::REC_SLOTS];
  logic [fcsd_pkg::REC_ADDR_W-1:0] cur_addr;
  logic [7:0]                      cur_data;
  logic [7:0]                      cur_low;
  logic                            step;
  logic                            unlock_ok;
  logic                            prefix_ok;
  logic                            below_depth;
  fcsd_pkg::op_t                   op_next;

  // Advance when the result register is free or being taken
  assign advance = !result_valid || !result_stall;
  assign step    = advance && item_valid;

  assign cur_addr    = item.bus_address[fcsd_pkg::REC_ADDR_W-1:0];
  assign cur_data    = item.bus_data;
  assign cur_low     = item.bus_address[7:0];
  assign below_depth = count < fcsd_pkg::COUNT_W'(fcsd_pkg::SEQUENCE_DEPTH);

  // Stored unlock and erase prefix compares
  assign unlock_ok = rec_addr[0] == fcsd_pkg::ADDR_A && rec_data[0] == fcsd_pkg::DATA_UNLOCK1 &&
                     rec_addr[1] == fcsd_pkg::ADDR_B && rec_data[1] == fcsd_pkg::DATA_UNLOCK2;
  assign prefix_ok = unlock_ok &&
                     rec_addr[2] == fcsd_pkg::ADDR_A && rec_data[2] == fcsd_pkg::DATA_ERASE &&
                     rec_addr[3] == fcsd_pkg::ADDR_A && rec_data[3] == fcsd_pkg::DATA_UNLOCK1 &&
                     rec_addr[4] == fcsd_pkg::ADDR_B && rec_data[4] == fcsd_pkg::DATA_UNLOCK2;

  // Match the record, with this write standing in the slot at the count
  always_comb begin
    op_next      = fcsd_pkg::OP_NONE;
    count_next   = count;
    id_flag_next = id_flag;
    if (below_depth) begin
      count_next = count + 1'b1;
      if (count == 4'd2 && unlock_ok && cur_addr == fcsd_pkg::ADDR_A &&
          cur_data == fcsd_pkg::DATA_ID) begin
        id_flag_next = 1'b1;
        count_next   = '0;
        op_next      = fcsd_pkg::OP_ID;
      end else if (count == 4'd5 && prefix_ok && cur_data == fcsd_pkg::DATA_SECTOR) begin
        count_next = '0;
        op_next    = fcsd_pkg::OP_SECTOR;
      end else if (count == 4'd5 && prefix_ok && cur_addr == fcsd_pkg::ADDR_A &&
                   cur_data == fcsd_pkg::DATA_CHIP) begin
        count_next = '0;
        op_next    = fcsd_pkg::OP_CHIP;
      end else if (count == 4'd3 && unlock_ok && rec_addr[2] == fcsd_pkg::ADDR_A &&
                   rec_data[2] == fcsd_pkg::DATA_PROGRAM) begin
        count_next = '0;
        op_next    = fcsd_pkg::OP_PROGRAM;
      end
    end
    // Drop the sequence on an address outside the command pair
    if (cur_low != fcsd_pkg::LOW_A && cur_low != fcsd_pkg::LOW_B) begin
      count_next = '0;
    end
    // Reset data ends the sequence and ID mode
    if (cur_data == fcsd_pkg::DATA_RESET) begin
      count_next   = '0;
      id_flag_next = 1'b0;
      if (op_next == fcsd_pkg::OP_NONE) begin
        op_next = fcsd_pkg::OP_RESET;
      end
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      id_flag <= 1'b0;
    end else if (step) begin
      count   <= count_next;
      id_flag <= id_flag_next;
    end
  end

  // Record the write while slots remain
  always_ff @(posedge clk) begin
    if (step && count < fcsd_pkg::COUNT_W'(fcsd_pkg::REC_SLOTS)) begin
      rec_addr[count[fcsd_pkg::SLOT_W-1:0]] <= cur_addr;
      rec_data[count[fcsd_pkg::SLOT_W-1:0]] <= cur_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.operation      <= op_next;
      result.target_address <= item.bus_address;
      result.program_data   <= item.bus_data;
      result.id_mode_active <= id_flag_next;
    end
  end

  // Reset data always leaves ID mode off
  a_reset_clears_id: assert property (@(posedge clk) disable iff (rst)
    step && cur_data == fcsd_pkg::DATA_RESET |=> !id_flag && !result.id_mode_active)
    else $error("reset data left ID mode active");

  // Count stays within the record depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fcsd_pkg::COUNT_W'(fcsd_pkg::SEQUENCE_DEPTH))
    else $error("sequence count beyond depth");

  // A recognized command restarts the sequence
  a_cmd_clears_count: assert property (@(posedge clk) disable iff (rst)
    step && (op_next == fcsd_pkg::OP_PROGRAM || op_next == fcsd_pkg::OP_SECTOR ||
             op_next == fcsd_pkg::OP_CHIP || op_next == fcsd_pkg::OP_ID) |=> count == '0)
    else $error("command did not clear the sequence count");

  // ID entry reports ID mode on its own result
  a_id_entry: assert property (@(posedge clk) disable iff (rst)
    step && op_next == fcsd_pkg::OP_ID |=> result_valid && result.id_mode_active)
    else $error("ID entry result without ID mode");

endmodule

/* sv/flash_command_sequence_decoder.sv */
// Flash command sequence decoder: bus writes in, decoded commands out.
// A request is captured in the input register, decoded, and its result is held in the result register.
// One request per cycle while result_stall is low; the input and result registers decouple the sides.
// Each request's decode is one compare pass over the six-slot record and the count.
// Reset (rst, synchronous): clears the sequence count, ID mode and both valid flags.
// The record slots are not cleared; only slots written in the current sequence are compared.
module flash_command_sequence_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  fcsd_pkg::req_item_t request,
  output logic                result_valid,
  input  logic                result_stall,
  output fcsd_pkg::res_item_t result
);

  logic                advance;
  logic                item_valid;
  fcsd_pkg::req_item_t item;

  // Capture incoming requests
  fcsd_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request       (request),
    .request_stall (request_stall),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  // Decode and register the result
  fcsd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
